@@ sv/rdiv_pkg.sv @@
// ----------------------------------------------------------------------------
// rdiv_pkg
// Shared widths, payload types and the in-flight work record for the
// pipelined 16/8 restoring divider.
// ----------------------------------------------------------------------------
package rdiv_pkg;

    localparam int DIVIDEND_WIDTH  = 16;
    localparam int DIVISOR_WIDTH   = 8;
    localparam int STEPS_PER_STAGE = 4;   // restoring steps done in one stage

    typedef struct packed {
        logic [DIVIDEND_WIDTH-1:0] dividend;
        logic [DIVISOR_WIDTH-1:0]  divisor;
    } t_in_item;

    typedef struct packed {
        logic [DIVIDEND_WIDTH-1:0] quotient;
        logic [DIVISOR_WIDTH-1:0]  remainder;
        logic                      divide_by_zero;
    } t_out_item;

    // acc starts as the dividend; each step shifts one dividend bit out the
    // top and one quotient bit in at the bottom, so it ends as the quotient.
    typedef struct packed {
        logic [DIVISOR_WIDTH:0]    part;
        logic [DIVIDEND_WIDTH-1:0] acc;
        logic [DIVISOR_WIDTH-1:0]  den;
        logic                      dz;
    } t_work;

endpackage

@@ sv/rdiv_stage.sv @@
// ----------------------------------------------------------------------------
// rdiv_stage
// One pipeline stage: STEPS restoring shift/compare/subtract steps followed
// by a register with its own valid bit and backpressure.
// ----------------------------------------------------------------------------
module rdiv_stage #(
    parameter int STEPS = rdiv_pkg::STEPS_PER_STAGE
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rdiv_pkg::t_work i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rdiv_pkg::t_work o_data
);
    import rdiv_pkg::*;

    logic  r_valid;
    t_work r_data;
    t_work n_data;

    always_comb begin
        t_work                  w;
        logic [DIVISOR_WIDTH:0] part;
        logic                   qbit;
        w = i_data;
        for (int s = 0; s < STEPS; s++) begin
            part = {w.part[DIVISOR_WIDTH-1:0], w.acc[DIVIDEND_WIDTH-1]};
            if (part >= {1'b0, w.den}) begin
                part = part - {1'b0, w.den};
                qbit = 1'b1;
            end else begin
                qbit = 1'b0;
            end
            w.acc  = {w.acc[DIVIDEND_WIDTH-2:0], qbit};
            w.part = part;
        end
        n_data = w;
    end

    // Stage can take a new item when empty or when its contents move on.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ sv/restoring_divider_16_by_8_core.sv @@
// ----------------------------------------------------------------------------
// restoring_divider_16_by_8_core
// Pipelined unsigned restoring divider, 16-bit dividend by 8-bit divisor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  : i_in_valid / o_in_ready, payload i_in_data (dividend,
//                    divisor). A transfer happens when both are high.
//   Output channel : o_out_valid / i_out_ready, payload o_out_data
//                    (quotient, remainder, divide_by_zero).
//   Stages         : NUM_STAGES = ceil(16 / STAGE_STEPS) stages, 4 at the
//                    default of 4 steps per stage. A result is registered
//                    in each stage in turn and is presented on the output
//                    from the last stage's register.
//   Throughput     : one division per cycle unless stalled; per-stage register.
//   Zero divisor   : divide_by_zero set, quotient all ones, remainder is the
//                    low byte of the dividend.
//   Reset          : synchronous, active low; clears all stage valid bits.
//   Stall          : each stage holds its item while the next is full and
//                    stalled; empty stages keep filling, so o_in_ready drops
//                    only when every stage holds an item and i_out_ready is low.
// ----------------------------------------------------------------------------
module restoring_divider_16_by_8_core #(
    parameter int STAGE_STEPS = rdiv_pkg::STEPS_PER_STAGE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rdiv_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rdiv_pkg::t_out_item o_out_data
);
    import rdiv_pkg::*;

    localparam int NUM_STAGES = (DIVIDEND_WIDTH + STAGE_STEPS - 1) / STAGE_STEPS;
    localparam int LAST_STEPS = DIVIDEND_WIDTH - STAGE_STEPS * (NUM_STAGES - 1);

    t_work w_data  [NUM_STAGES+1];
    logic  w_valid [NUM_STAGES+1];
    logic  w_ready [NUM_STAGES+1];

    assign w_data[0].part = '0;
    assign w_data[0].acc  = i_in_data.dividend;
    assign w_data[0].den  = i_in_data.divisor;
    assign w_data[0].dz   = (i_in_data.divisor == '0);
    assign w_valid[0]     = i_in_valid;
    assign o_in_ready     = w_ready[0];

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        localparam int G_STEPS = (g == NUM_STAGES - 1) ? LAST_STEPS : STAGE_STEPS;
        rdiv_stage #(
            .STEPS (G_STEPS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    assign w_ready[NUM_STAGES]       = i_out_ready;
    assign o_out_valid               = w_valid[NUM_STAGES];
    assign o_out_data.quotient       = w_data[NUM_STAGES].acc;
    assign o_out_data.remainder      = w_data[NUM_STAGES].part[DIVISOR_WIDTH-1:0];
    assign o_out_data.divide_by_zero = w_data[NUM_STAGES].dz;

    // Zero divisor subtracts nothing each step, so every quotient bit is set.
    a_dz_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.divide_by_zero |-> o_out_data.quotient == '1)
        else $error("zero divisor result without all-ones quotient");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !w_data[NUM_STAGES].dz |->
            w_data[NUM_STAGES].part < {1'b0, w_data[NUM_STAGES].den})
        else $error("remainder not below divisor");

    a_full_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input blocked while output side can drain");

    a_dz_matches_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.divide_by_zero == (w_data[NUM_STAGES].den == '0))
        else $error("divide_by_zero flag lost its divisor");

endmodule
